// ----- sv/lacp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LACP agent package
// Types, register indexes, event codes, state octet masks and the result
// record that the LACP agent modules share.
// ----------------------------------------------------------------------------
package lacp_pkg;

    // Event codes carried in the opcode field.
    localparam logic [2:0] OP_ENABLE  = 3'd0;
    localparam logic [2:0] OP_DISABLE = 3'd1;
    localparam logic [2:0] OP_PDU     = 3'd2;
    localparam logic [2:0] OP_CUR_EXP = 3'd3;
    localparam logic [2:0] OP_EXPIRED = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_SYS_PRI = 2'd0;
    localparam logic [1:0] REG_SYS_MAC = 2'd1;
    localparam logic [1:0] REG_PORT_ID = 2'd2;
    localparam logic [1:0] REG_KEY     = 2'd3;

    // Timer commands.
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_AGGR_OFF = 3'd1;
    localparam logic [2:0] ERR_NOT_SYNC = 3'd2;
    localparam logic [2:0] ERR_COL_OFF  = 3'd3;
    localparam logic [2:0] ERR_DIS_OFF  = 3'd4;

    // Transmit reasons.
    localparam logic [3:0] RSN_NONE     = 4'd0;
    localparam logic [3:0] RSN_ENABLED  = 4'd1;
    localparam logic [3:0] RSN_INFO     = 4'd2;
    localparam logic [3:0] RSN_ACT      = 4'd3;
    localparam logic [3:0] RSN_AGG      = 4'd4;
    localparam logic [3:0] RSN_SYNC     = 4'd5;
    localparam logic [3:0] RSN_COL      = 4'd6;
    localparam logic [3:0] RSN_DIS      = 4'd7;
    localparam logic [3:0] RSN_SYNC_SET = 4'd8;
    localparam logic [3:0] RSN_COL_SET  = 4'd9;
    localparam logic [3:0] RSN_DIS_SET  = 4'd10;
    localparam logic [3:0] RSN_CUR_EXP  = 4'd11;

    // State octet bits, 802.1AX order.
    localparam logic [7:0] FLG_ACT = 8'h01;
    localparam logic [7:0] FLG_TMO = 8'h02;
    localparam logic [7:0] FLG_AGG = 8'h04;
    localparam logic [7:0] FLG_SYN = 8'h08;
    localparam logic [7:0] FLG_COL = 8'h10;
    localparam logic [7:0] FLG_DIS = 8'h20;
    localparam logic [7:0] FLG_DEF = 8'h40;
    localparam logic [7:0] FLG_EXP = 8'h80;
    localparam logic [7:0] FLG_SCD = FLG_SYN | FLG_COL | FLG_DIS;

    typedef enum logic [1:0] {
        MODE_STOPPED   = 2'd0,
        MODE_CURRENT   = 2'd1,
        MODE_EXPIRED   = 2'd2,
        MODE_DEFAULTED = 2'd3
    } mode_t;

    // System and port identity as advertised in a PDU.
    typedef struct packed {
        logic [15:0] sys_prio;
        logic [47:0] sys_mac;
        logic [31:0] port_id;
        logic [15:0] key;
    } sys_id_t;

    // One event transaction.
    typedef struct packed {
        logic [2:0] opcode;
        sys_id_t    peer;
        logic [7:0] peer_state;
        sys_id_t    echo;
        logic [7:0] echo_state;
    } event_t;

    // One result transaction.
    typedef struct packed {
        logic [1:0] tx_count;
        logic [1:0] notify_count;
        logic [1:0] periodic_cmd;
        logic [1:0] churn_cmd;
        logic [1:0] current_cmd;
        mode_t      agent_mode;
        logic [7:0] actor_flags;
        logic       converged;
        logic [2:0] error_code;
        logic [3:0] tx_reason;
    } result_t;

endpackage
`default_nettype wire

// ----- sv/lacp_agent_state_machine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LACP agent state machine
// Per-port LACP actor agent: takes enable, disable, PDU and timer-expiry
// events and returns transmit and notice counts, timer commands and status.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  s_        s_valid / s_ready       opcode, peer_*, echo_* (one event)
//  m_        m_valid / m_ready       counts, timer commands, status snapshot
//  cfg_      cfg_valid / cfg_ready   cfg_index, cfg_wdata (always ready)
//
//  One event per cycle while the result register is free: the event logic is
//  combinational between the input register and the result register, and
//  the agent state updates when the result register loads.
//  A stall on m_ready holds the result; one more event waits in the input
//  register before s_ready drops.
//  Reset (aresetn, synchronous, active low) clears the agent state and the
//  configuration registers to zero.
// ----------------------------------------------------------------------------
module lacp_agent_state_machine (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_opcode,
    input  wire logic [15:0] s_peer_sys_prio,
    input  wire logic [47:0] s_peer_sys_mac,
    input  wire logic [31:0] s_peer_port_id,
    input  wire logic [15:0] s_peer_key,
    input  wire logic [7:0]  s_peer_state,
    input  wire logic [15:0] s_echo_sys_prio,
    input  wire logic [47:0] s_echo_sys_mac,
    input  wire logic [31:0] s_echo_port_id,
    input  wire logic [15:0] s_echo_key,
    input  wire logic [7:0]  s_echo_state,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_tx_count,
    output logic [1:0]       m_notify_count,
    output logic [1:0]       m_periodic_cmd,
    output logic [1:0]       m_churn_cmd,
    output logic [1:0]       m_current_cmd,
    output logic [1:0]       m_agent_mode,
    output logic [7:0]       m_actor_flags,
    output logic             m_converged,
    output logic [2:0]       m_error_code,
    output logic [3:0]       m_tx_reason,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [47:0] cfg_wdata
);
    import lacp_pkg::*;

    logic    in_valid_reg, in_valid_next;
    event_t  in_evt_reg;
    logic    out_valid_reg, out_valid_next;
    result_t res_reg;
    result_t core_res;
    sys_id_t actor_cfg;
    logic    out_free;
    logic    fire;
    logic    s_take;

    // Handshake: the result register frees when empty or taken downstream.
    assign out_free  = !out_valid_reg || m_ready;
    assign fire      = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign s_take    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register captures the event transaction.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_evt_reg.opcode        <= s_opcode;
            in_evt_reg.peer.sys_prio <= s_peer_sys_prio;
            in_evt_reg.peer.sys_mac  <= s_peer_sys_mac;
            in_evt_reg.peer.port_id  <= s_peer_port_id;
            in_evt_reg.peer.key      <= s_peer_key;
            in_evt_reg.peer_state    <= s_peer_state;
            in_evt_reg.echo.sys_prio <= s_echo_sys_prio;
            in_evt_reg.echo.sys_mac  <= s_echo_sys_mac;
            in_evt_reg.echo.port_id  <= s_echo_port_id;
            in_evt_reg.echo.key      <= s_echo_key;
            in_evt_reg.echo_state    <= s_echo_state;
        end
    end

    lacp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (cfg_valid),
        .wr_index  (cfg_index),
        .wr_data   (cfg_wdata),
        .actor_cfg (actor_cfg)
    );

    lacp_agent_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (fire),
        .evt       (in_evt_reg),
        .actor_cfg (actor_cfg),
        .res       (core_res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= core_res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_tx_count     = res_reg.tx_count;
    assign m_notify_count = res_reg.notify_count;
    assign m_periodic_cmd = res_reg.periodic_cmd;
    assign m_churn_cmd    = res_reg.churn_cmd;
    assign m_current_cmd  = res_reg.current_cmd;
    assign m_agent_mode   = res_reg.agent_mode;
    assign m_actor_flags  = res_reg.actor_flags;
    assign m_converged    = res_reg.converged;
    assign m_error_code   = res_reg.error_code;
    assign m_tx_reason    = res_reg.tx_reason;

    // Counts never exceed two per event.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_tx_count != 2'd3) && (m_notify_count != 2'd3)))
        else $error("count out of range");

    // A waiting event is kept while the result register is blocked.
    a_hold_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> in_valid_reg)
        else $error("event dropped during a stall");

    // A stalled result stays valid and unchanged.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(res_reg)))
        else $error("result changed during a stall");

endmodule
`default_nettype wire

// ----- sv/lacp_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LACP configuration registers
// Holds our advertised system priority, MAC, port id and key, written
// through the configuration channel.
// ----------------------------------------------------------------------------
module lacp_cfg_regs (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            wr_en,
    input  wire logic [1:0]      wr_index,
    input  wire logic [47:0]     wr_data,
    output lacp_pkg::sys_id_t    actor_cfg
);
    import lacp_pkg::*;

    sys_id_t cfg_reg;
    sys_id_t cfg_next;

    // Select the register addressed by a write transaction.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_SYS_PRI: cfg_next.sys_prio = wr_data[15:0];
                REG_SYS_MAC: cfg_next.sys_mac  = wr_data;
                REG_PORT_ID: cfg_next.port_id  = wr_data[31:0];
                REG_KEY:     cfg_next.key      = wr_data[15:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign actor_cfg = cfg_reg;

endmodule
`default_nettype wire

// ----- sv/lacp_agent_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LACP agent core
// Agent state registers and the single-pass event logic that computes the
// next state and the result of one event.
// ----------------------------------------------------------------------------
module lacp_agent_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  lacp_pkg::event_t     evt,
    input  lacp_pkg::sys_id_t    actor_cfg,
    output lacp_pkg::result_t    res
);
    import lacp_pkg::*;

    logic       attached_reg,      attached_next;
    logic       enabled_reg,       enabled_next;
    mode_t      mode_reg,          mode_next;
    logic [7:0] actor_octet_reg,   actor_octet_next;
    sys_id_t    partner_reg,       partner_next;
    logic [7:0] partner_octet_reg, partner_octet_next;
    logic       converged_reg,     converged_next;
    logic [2:0] last_error_reg,    last_error_next;
    logic [3:0] last_reason_reg,   last_reason_next;
    logic       churn_running_reg, churn_running_next;
    sys_id_t    actor_id_reg,      actor_id_next;

    logic [1:0] tx_cnt;
    logic [1:0] note_cnt;
    logic [1:0] per_cmd;
    logic [1:0] churn_cmd;
    logic [1:0] cur_cmd;
    logic [2:0] prev_err;
    logic [7:0] diff;
    logic       ntt;
    logic       done;

    // Event logic: next state and counts for the event at the input register.
    always_comb begin
        attached_next      = attached_reg;
        enabled_next       = enabled_reg;
        mode_next          = mode_reg;
        actor_octet_next   = actor_octet_reg;
        partner_next       = partner_reg;
        partner_octet_next = partner_octet_reg;
        converged_next     = converged_reg;
        last_error_next    = last_error_reg;
        last_reason_next   = last_reason_reg;
        churn_running_next = churn_running_reg;
        actor_id_next      = actor_id_reg;
        tx_cnt             = 2'd0;
        note_cnt           = 2'd0;
        per_cmd            = CMD_NONE;
        churn_cmd          = CMD_NONE;
        cur_cmd            = CMD_NONE;
        prev_err           = last_error_reg;
        diff               = 8'h00;
        ntt                = 1'b0;
        done               = 1'b0;

        if (evt.opcode == OP_ENABLE) begin
            // A repeat enable with unchanged identity only re-notifies, and only when converged.
            if (enabled_reg && (actor_cfg == actor_id_reg)) begin
                if (converged_reg) begin
                    note_cnt = 2'd1;
                end
            end else begin
                actor_id_next    = actor_cfg;
                attached_next    = 1'b1;
                enabled_next     = 1'b1;
                mode_next        = MODE_CURRENT;
                actor_octet_next = FLG_ACT | FLG_TMO | FLG_AGG;
                last_reason_next = RSN_ENABLED;
                tx_cnt           = 2'd1;
                per_cmd          = CMD_START;
                cur_cmd          = CMD_START;
            end
        end else if (evt.opcode == OP_DISABLE) begin
            per_cmd            = CMD_STOP;
            churn_cmd          = CMD_STOP;
            cur_cmd            = CMD_STOP;
            attached_next      = 1'b0;
            enabled_next       = 1'b0;
            converged_next     = 1'b0;
            mode_next          = MODE_STOPPED;
            actor_octet_next   = 8'h00;
            partner_octet_next = 8'h00;
            last_error_next    = ERR_NONE;
            last_reason_next   = RSN_NONE;
            partner_next       = '0;
            actor_id_next      = '0;
        end else if (attached_reg) begin
            if (evt.opcode == OP_PDU) begin
                mode_next        = MODE_CURRENT;
                actor_octet_next = (actor_octet_reg | FLG_TMO) & ~(FLG_EXP | FLG_DEF);

                // Partner update: a new partner identity drops sync.
                if (evt.peer != partner_reg) begin
                    if (converged_reg) begin
                        converged_next = 1'b0;
                        note_cnt       = note_cnt + 2'd1;
                    end
                    actor_octet_next = actor_octet_next & ~FLG_SCD;
                end
                if (((partner_octet_reg ^ evt.peer_state) & FLG_TMO) != 8'h00) begin
                    per_cmd = CMD_START;
                end
                partner_next       = evt.peer;
                partner_octet_next = evt.peer_state;

                // Compare the peer's echo of us against what we advertise.
                diff = evt.echo_state ^ actor_octet_next;
                ntt  = 1'b1;
                priority if (evt.echo != actor_id_reg) begin
                    last_reason_next = RSN_INFO;
                end else if ((diff & FLG_ACT) != 8'h00) begin
                    last_reason_next = RSN_ACT;
                end else if ((diff & FLG_AGG) != 8'h00) begin
                    last_reason_next = RSN_AGG;
                end else if ((diff & FLG_SYN) != 8'h00) begin
                    last_reason_next = RSN_SYNC;
                end else if ((diff & FLG_COL) != 8'h00) begin
                    last_reason_next = RSN_COL;
                end else if ((diff & FLG_DIS) != 8'h00) begin
                    last_reason_next = RSN_DIS;
                end else begin
                    ntt = 1'b0;
                end
                if (ntt) begin
                    actor_octet_next = actor_octet_next & ~FLG_SCD;
                end

                // If the peer aggregates: walk sync, collecting, distributing in order.
                if ((evt.peer_state & FLG_AGG) == 8'h00) begin
                    if (last_error_reg != ERR_AGGR_OFF) begin
                        last_error_next    = ERR_AGGR_OFF;
                        mode_next          = MODE_DEFAULTED;
                        actor_octet_next   = (actor_octet_next | FLG_DEF) &
                                             ~(FLG_TMO | FLG_SCD);
                        churn_running_next = 1'b0;
                        churn_cmd          = CMD_STOP;
                        converged_next     = 1'b0;
                        note_cnt           = note_cnt + 2'd1;
                        tx_cnt             = tx_cnt + {1'b0, enabled_reg};
                    end
                end else if (!ntt) begin
                    if ((actor_octet_next & FLG_SYN) == 8'h00) begin
                        actor_octet_next = actor_octet_next | FLG_SYN;
                        last_reason_next = RSN_SYNC_SET;
                        ntt              = 1'b1;
                    end
                    if ((evt.peer_state & FLG_SYN) == 8'h00) begin
                        last_error_next = ERR_NOT_SYNC;
                        done            = 1'b1;
                    end
                    if (!done) begin
                        if ((actor_octet_next & FLG_COL) == 8'h00) begin
                            actor_octet_next = actor_octet_next | FLG_COL;
                            last_reason_next = RSN_COL_SET;
                            ntt              = 1'b1;
                        end
                        if ((evt.peer_state & FLG_COL) == 8'h00) begin
                            last_error_next = ERR_COL_OFF;
                            done            = 1'b1;
                        end
                    end
                    if (!done) begin
                        if ((actor_octet_next & FLG_DIS) == 8'h00) begin
                            actor_octet_next = actor_octet_next | FLG_DIS;
                            last_reason_next = RSN_DIS_SET;
                            ntt              = 1'b1;
                        end
                        if ((evt.peer_state & FLG_DIS) == 8'h00) begin
                            last_error_next = ERR_DIS_OFF;
                            done            = 1'b1;
                        end
                    end
                    if (done) begin
                        converged_next = 1'b0;
                    end else begin
                        last_error_next = ERR_NONE;
                        if (!converged_next) begin
                            converged_next = 1'b1;
                            note_cnt       = note_cnt + 2'd1;
                        end
                        actor_octet_next = actor_octet_next & ~FLG_TMO;
                    end
                end
                if (ntt) begin
                    tx_cnt = tx_cnt + {1'b0, enabled_reg};
                end

                // Churn detection timer follows convergence and error changes.
                if (!converged_next && (prev_err == last_error_next) &&
                    !churn_running_next) begin
                    churn_cmd          = CMD_START;
                    churn_running_next = 1'b1;
                end else if (converged_next || (prev_err != last_error_next)) begin
                    churn_cmd          = CMD_STOP;
                    churn_running_next = 1'b0;
                end
                cur_cmd = CMD_START;
            end else if (evt.opcode == OP_CUR_EXP) begin
                mode_next        = MODE_EXPIRED;
                actor_octet_next = actor_octet_reg | FLG_EXP | FLG_TMO;
                if ((partner_octet_reg & FLG_TMO) == 8'h00) begin
                    partner_octet_next = partner_octet_reg | FLG_TMO;
                    per_cmd            = CMD_START;
                end
                last_reason_next = RSN_CUR_EXP;
                tx_cnt           = {1'b0, enabled_reg};
                cur_cmd          = CMD_START;
            end else if (evt.opcode == OP_EXPIRED) begin
                mode_next          = MODE_DEFAULTED;
                actor_octet_next   = (actor_octet_reg | FLG_DEF) & ~(FLG_TMO | FLG_SCD);
                churn_running_next = 1'b0;
                churn_cmd          = CMD_STOP;
                cur_cmd            = CMD_STOP;
                converged_next     = 1'b0;
                note_cnt           = 2'd1;
                tx_cnt             = {1'b0, enabled_reg};
            end
        end

        res.tx_count     = tx_cnt;
        res.notify_count = note_cnt;
        res.periodic_cmd = per_cmd;
        res.churn_cmd    = churn_cmd;
        res.current_cmd  = cur_cmd;
        res.agent_mode   = mode_next;
        res.actor_flags  = actor_octet_next;
        res.converged    = converged_next;
        res.error_code   = last_error_next;
        res.tx_reason    = last_reason_next;
    end

    // State registers advance once per processed event.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attached_reg      <= 1'b0;
            enabled_reg       <= 1'b0;
            mode_reg          <= MODE_STOPPED;
            actor_octet_reg   <= 8'h00;
            partner_reg       <= '0;
            partner_octet_reg <= 8'h00;
            converged_reg     <= 1'b0;
            last_error_reg    <= ERR_NONE;
            last_reason_reg   <= RSN_NONE;
            churn_running_reg <= 1'b0;
            actor_id_reg      <= '0;
        end else if (step) begin
            attached_reg      <= attached_next;
            enabled_reg       <= enabled_next;
            mode_reg          <= mode_next;
            actor_octet_reg   <= actor_octet_next;
            partner_reg       <= partner_next;
            partner_octet_reg <= partner_octet_next;
            converged_reg     <= converged_next;
            last_error_reg    <= last_error_next;
            last_reason_reg   <= last_reason_next;
            churn_running_reg <= churn_running_next;
            actor_id_reg      <= actor_id_next;
        end
    end

    // The agent is attached exactly when it is enabled.
    a_attach_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        attached_reg == enabled_reg)
        else $error("attached and enabled disagree");

    // The mode is stopped exactly when the agent is detached.
    a_mode_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_STOPPED) == !attached_reg)
        else $error("mode out of step with attachment");

    // A converged agent carries no error.
    a_conv_no_err: assert property (@(posedge aclk) disable iff (!aresetn)
        converged_reg |-> (last_error_reg == ERR_NONE))
        else $error("converged with an error code");

endmodule
`default_nettype wire
